// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tile background pixel engine.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TBPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication from a condition to a consequence at the following clock edge.
`define TBPE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tbpe_pkg.sv =====
// Package for the tile background pixel engine: constants, codes and types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tbpe_pkg;

  localparam int LINE_DOTS    = 456;
  localparam int SCREEN_WIDTH = 160;
  localparam int QUEUE_DEPTH  = 16;
  localparam int SCAN_DOTS    = 80;
  localparam int LAST_VISIBLE = 143;
  localparam int LAST_LINE    = 153;

  localparam int VRAM_AW = 13;
  localparam int VRAM_DEPTH = 1 << VRAM_AW;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int TILE_PIX = 8;

  localparam logic [VRAM_AW-1:0] MAP_LOW_BASE  = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE = 13'h1C00;
  localparam logic [VRAM_AW-1:0] SIGNED_BASE   = 13'h0800;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_TILE  = 2'd0,
    PH_LOW   = 2'd1,
    PH_HIGH  = 2'd2,
    PH_SLEEP = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_LCDC  = 3'd0,
    REG_SCX   = 3'd1,
    REG_SCY   = 3'd2,
    REG_WX    = 3'd3,
    REG_WY    = 3'd4,
    REG_LYC   = 3'd5,
    REG_STAT  = 3'd6,
    REG_NONE  = 3'd7
  } reg_e;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
    logic snoop;
  } vram_ctl_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } queue_ctl_t;

endpackage

// ===== sv/tbpe_vram.sv =====
// Video memory of the tile background pixel engine: one write and one read port.
// Read data is registered; a held prefetch follows later writes to its address.
// Depends on tbpe_pkg.
`timescale 1ns / 1ps
module tbpe_vram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbpe_pkg::vram_ctl_t              ctl_i,
  input  logic [tbpe_pkg::VRAM_AW-1:0]     waddr_i,
  input  logic [7:0]                       wdata_i,
  input  logic [tbpe_pkg::VRAM_AW-1:0]     raddr_i,
  output logic [7:0]                       rdata_o
);

  logic [7:0]                   mem [tbpe_pkg::VRAM_DEPTH];
  logic [7:0]                   rdata_q;
  logic                         snoop_q;
  logic [tbpe_pkg::VRAM_AW-1:0] snoop_addr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end else if (ctl_i.we && snoop_q && (waddr_i == snoop_addr_q)) begin
      rdata_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snoop_q <= 1'b0;
    end else if (ctl_i.re) begin
      snoop_q <= ctl_i.snoop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      snoop_addr_q <= raddr_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tbpe_pixel_queue.sv =====
// Pixel queue of the tile background pixel engine: eight-pixel push, one-pixel pop.
// Push lands before pop in the same transaction. Depends on tbpe_pkg.
`timescale 1ns / 1ps
module tbpe_pixel_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tbpe_pkg::queue_ctl_t            ctl_i,
  input  logic [2*tbpe_pkg::TILE_PIX-1:0] push_px_i,
  output logic [1:0]                      head_o,
  output logic                            avail_o,
  output logic [tbpe_pkg::QCNT_W-1:0]     count_o
);

  logic [1:0]                  q_q [tbpe_pkg::QUEUE_DEPTH];
  logic [1:0]                  q_d [tbpe_pkg::QUEUE_DEPTH];
  logic [1:0]                  pushed [tbpe_pkg::QUEUE_DEPTH];
  logic [tbpe_pkg::QCNT_W-1:0] cnt_q, cnt_d, cnt_push;
  logic [tbpe_pkg::QCNT_W:0]   cnt_sum;

  always_comb begin
    for (int i = 0; i < tbpe_pkg::QUEUE_DEPTH; i++) begin
      pushed[i] = q_q[i];
      if (ctl_i.push && (i >= int'(cnt_q)) && (i - int'(cnt_q) < tbpe_pkg::TILE_PIX)) begin
        pushed[i] = push_px_i[2*(i - int'(cnt_q)) +: 2];
      end
    end
    cnt_sum = {1'b0, cnt_q} + (tbpe_pkg::QCNT_W+1)'(tbpe_pkg::TILE_PIX);
    if (!ctl_i.push) begin
      cnt_push = cnt_q;
    end else if (cnt_sum > (tbpe_pkg::QCNT_W+1)'(tbpe_pkg::QUEUE_DEPTH)) begin
      cnt_push = tbpe_pkg::QCNT_W'(tbpe_pkg::QUEUE_DEPTH);
    end else begin
      cnt_push = cnt_sum[tbpe_pkg::QCNT_W-1:0];
    end
    for (int i = 0; i < tbpe_pkg::QUEUE_DEPTH; i++) begin
      if (ctl_i.pop && (i < tbpe_pkg::QUEUE_DEPTH - 1)) begin
        q_d[i] = pushed[i+1];
      end else begin
        q_d[i] = pushed[i];
      end
    end
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.pop && (cnt_push != '0)) begin
      cnt_d = cnt_push - 1'b1;
    end else begin
      cnt_d = cnt_push;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tbpe_pkg::QUEUE_DEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = pushed[0];
  assign avail_o = (cnt_push != '0);
  assign count_o = cnt_q;

endmodule

// ===== sv/tile_background_pixel_engine_unit.sv =====
// Top level of the tile background pixel engine: dot timing, fetcher, output stage.
// Depends on tbpe_pkg, tbpe_vram, tbpe_pixel_queue and assert_macros.svh.
//
//  channel  | direction | handshake                | payload
//  s_axis   | in        | s_axis_tvalid/tready     | tuser cmd; tdata addr, data
//  m_axis   | out       | m_axis_tvalid/tready     | tdata result fields
//  cfg      | in        | cfg_valid_i/cfg_ready_o  | cfg_addr_i, cfg_data_i
//
// One transaction per clock while s_axis is ready; each result is registered and appears in the cycle after its input.
// The single video memory read port serves at most one fetch read per dot.
// Reset clears timing, fetcher and queue count; video memory is not cleared.
// s_axis stays ready while the output register is empty or being drained, except in
// the cycle after a register write that lands on a pending high-plane prefetch.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tile_background_pixel_engine_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [12:0] vram_addr, [20:13] vram_data, [23:21] zero
  input  logic [tbpe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] pixel_valid, [2:1] pixel_color, [10:3] pixel_column, [18:11] line_number,
  // [20:19] display_mode, [21] status_irq, [22] vblank_irq, [23] zero
  output logic [tbpe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_addr_i,
  input  logic [7:0]                        cfg_data_i
);

  logic [7:0] lcdc_q, scx_q, scy_q, wx_q, wy_q, lyc_q, stat_en_q;

  tbpe_pkg::mode_e  mode_q, mode_d;
  tbpe_pkg::phase_e phase_q, phase_d;
  logic [8:0] dot_q, dot_d;
  logic [7:0] line_q, line_d;
  logic [7:0] col_q, col_d;
  logic [8:0] col_inc;
  logic [5:0] fcol_q, fcol_d;
  logic [7:0] fline_q, fline_d;
  logic       tog_q, tog_d;
  logic [7:0] tile_q, tile_d;
  logic [7:0] plow_q, plow_d;
  logic [2:0] disc_q, disc_d;

  logic acc, tick;
  logic cfg_fire, pend_d, refetch_q;
  logic out_valid_q;
  logic [tbpe_pkg::OUT_DATA_W-1:0] out_data_q;

  tbpe_pkg::vram_ctl_t  vctl;
  tbpe_pkg::queue_ctl_t qctl;
  logic [tbpe_pkg::VRAM_AW-1:0] raddr;
  logic [7:0] rdata;
  logic [2*tbpe_pkg::TILE_PIX-1:0] push_px;
  logic [1:0] head;
  logic       avail;
  logic [tbpe_pkg::QCNT_W-1:0] qcount;

  logic       win, high_map;
  logic [7:0] bg_y;
  logic [4:0] ty, bg_x;
  logic [5:0] tx;
  logic [tbpe_pkg::VRAM_AW-1:0] map_addr, tile_base, tile_row_addr;
  logic [7:0] row_sum;

  logic       pvalid, stat_irq, vbl_irq;
  logic [1:0] pcolor;
  logic [7:0] pcol;

  assign acc  = s_axis_tvalid && s_axis_tready;
  assign tick = acc && (s_axis_tuser == tbpe_pkg::CMD_TICK);
  assign s_axis_tready = (!out_valid_q || m_axis_tready) && !refetch_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= '0; scx_q <= '0; scy_q <= '0; wx_q <= '0;
      wy_q <= '0; lyc_q <= '0; stat_en_q <= '0;
    end else if (cfg_valid_i) begin
      case (tbpe_pkg::reg_e'(cfg_addr_i))
        tbpe_pkg::REG_LCDC: lcdc_q    <= cfg_data_i;
        tbpe_pkg::REG_SCX:  scx_q     <= cfg_data_i;
        tbpe_pkg::REG_SCY:  scy_q     <= cfg_data_i;
        tbpe_pkg::REG_WX:   wx_q      <= cfg_data_i;
        tbpe_pkg::REG_WY:   wy_q      <= cfg_data_i;
        tbpe_pkg::REG_LYC:  lyc_q     <= cfg_data_i;
        tbpe_pkg::REG_STAT: stat_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // fetch addresses and the pixel row to push
  always_comb begin
    win = lcdc_q[5] && (line_q >= wy_q) && (({1'b0, col_q} + 9'd7) >= {1'b0, wx_q});
    high_map = win ? lcdc_q[6] : lcdc_q[3];
    bg_y = line_q + scy_q;
    bg_x = scx_q[7:3] + fcol_q[4:0];
    ty = win ? line_q[7:3] : bg_y[7:3];
    tx = win ? fcol_q : {1'b0, bg_x};
    map_addr = (high_map ? tbpe_pkg::MAP_HIGH_BASE : tbpe_pkg::MAP_LOW_BASE)
             + {3'b0, ty, 5'b0} + {7'b0, tx};
    row_sum = fline_q + scy_q;
    tile_base = lcdc_q[4] ? {1'b0, tile_q, 4'b0}
              : tbpe_pkg::SIGNED_BASE + {1'b0, tile_q ^ 8'h80, 4'b0};
    tile_row_addr = tile_base + {9'b0, row_sum[2:0], 1'b0};
    for (int k = 0; k < tbpe_pkg::TILE_PIX; k++) begin
      push_px[2*k +: 2] = {rdata[tbpe_pkg::TILE_PIX-1-k], plow_q[tbpe_pkg::TILE_PIX-1-k]};
    end
  end

  always_comb begin
    mode_d = mode_q; phase_d = phase_q; dot_d = dot_q; line_d = line_q;
    col_d = col_q; fcol_d = fcol_q; fline_d = fline_q; tog_d = tog_q;
    tile_d = tile_q; plow_d = plow_q; disc_d = disc_q;
    col_inc = {1'b0, col_q} + 9'd1;
    vctl = '0; qctl = '0; raddr = map_addr;
    pvalid = 1'b0; pcolor = '0; pcol = '0; stat_irq = 1'b0; vbl_irq = 1'b0;
    vctl.we = acc && (s_axis_tuser == tbpe_pkg::CMD_WRITE);
    if (refetch_q) begin
      // reissue the high plane prefetch with the new register values
      vctl.re = 1'b1; vctl.snoop = 1'b1; raddr = tile_row_addr + 13'd1;
    end
    if (tick) begin
      if (!lcdc_q[7]) begin
        dot_d = '0; mode_d = tbpe_pkg::MODE_SCAN; line_d = '0; stat_irq = stat_en_q[5];
      end else begin
        dot_d = dot_q + 9'd1;
        case (mode_q)
          tbpe_pkg::MODE_SCAN: begin
            if (dot_d >= 9'(tbpe_pkg::SCAN_DOTS)) begin
              fcol_d = '0; phase_d = tbpe_pkg::PH_TILE; tog_d = 1'b1;
              mode_d = tbpe_pkg::MODE_XFER; disc_d = '0; col_d = '0; qctl.clear = 1'b1;
            end
          end
          tbpe_pkg::MODE_XFER: begin
            tog_d = ~tog_q;
            case (phase_q)
              tbpe_pkg::PH_TILE: begin
                if (tog_d) begin
                  phase_d = tbpe_pkg::PH_LOW; tile_d = rdata;
                end else begin
                  fline_d = line_q; vctl.re = 1'b1; raddr = map_addr;
                end
              end
              tbpe_pkg::PH_LOW: begin
                raddr = tile_row_addr;
                vctl.re = 1'b1;
                if (tog_d) begin
                  // prefetch the high plane, keep the low plane
                  phase_d = tbpe_pkg::PH_HIGH; plow_d = rdata;
                  raddr = tile_row_addr + 13'd1; vctl.snoop = 1'b1;
                end
              end
              tbpe_pkg::PH_HIGH: begin
                if (tog_d) begin
                  phase_d = tbpe_pkg::PH_SLEEP;
                end else begin
                  qctl.push = 1'b1; fcol_d = fcol_q + 6'd1;
                end
              end
              tbpe_pkg::PH_SLEEP: begin
                if (tog_d) begin
                  phase_d = tbpe_pkg::PH_TILE;
                end
              end
              default: ;
            endcase
            if (avail) begin
              qctl.pop = 1'b1;
              if (disc_q < scx_q[2:0]) begin
                disc_d = disc_q + 3'd1;
              end else begin
                pvalid = 1'b1; pcolor = head; pcol = col_q; col_d = col_inc[7:0];
                if (col_inc >= 9'(tbpe_pkg::SCREEN_WIDTH)) begin
                  mode_d = tbpe_pkg::MODE_HBLANK; stat_irq = stat_en_q[3];
                end
              end
            end
          end
          tbpe_pkg::MODE_HBLANK: begin
            if (dot_d >= 9'(tbpe_pkg::LINE_DOTS)) begin
              dot_d = '0; line_d = line_q + 8'd1;
              if (stat_en_q[6] && (lyc_q == line_d)) stat_irq = 1'b1;
              if (line_d <= 8'(tbpe_pkg::LAST_VISIBLE)) begin
                mode_d = tbpe_pkg::MODE_SCAN;
                if (stat_en_q[5]) stat_irq = 1'b1;
              end else begin
                vbl_irq = 1'b1; mode_d = tbpe_pkg::MODE_VBLANK;
                if (stat_en_q[4]) stat_irq = 1'b1;
              end
            end
          end
          default: begin
            if (dot_d >= 9'(tbpe_pkg::LINE_DOTS)) begin
              dot_d = '0;
              if (line_q >= 8'(tbpe_pkg::LAST_LINE)) begin
                line_d = '0; mode_d = tbpe_pkg::MODE_SCAN; stat_irq = stat_en_q[5];
              end else begin
                line_d = line_q + 8'd1;
              end
            end
          end
        endcase
      end
    end
  end

  assign pend_d = (mode_d == tbpe_pkg::MODE_XFER) && (phase_d == tbpe_pkg::PH_HIGH) && tog_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbpe_pkg::MODE_SCAN; phase_q <= tbpe_pkg::PH_TILE;
      dot_q <= '0; line_q <= '0; col_q <= '0; fcol_q <= '0; fline_q <= '0;
      tog_q <= 1'b1; tile_q <= '0; plow_q <= '0; disc_q <= '0;
    end else begin
      mode_q <= mode_d; phase_q <= phase_d;
      dot_q <= dot_d; line_q <= line_d; col_q <= col_d; fcol_q <= fcol_d;
      fline_q <= fline_d; tog_q <= tog_d; tile_q <= tile_d; plow_q <= plow_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refetch_q <= 1'b0;
    end else begin
      refetch_q <= cfg_fire && pend_d;
    end
  end

  // hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= acc || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= {1'b0, vbl_irq, stat_irq, mode_d, line_d, pcol, pcolor, pvalid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  tbpe_vram u_vram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (vctl),
    .waddr_i (s_axis_tdata[12:0]),
    .wdata_i (s_axis_tdata[20:13]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tbpe_pixel_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (qctl),
    .push_px_i (push_px),
    .head_o    (head),
    .avail_o   (avail),
    .count_o   (qcount)
  );

  `TBPE_ASSERT(a_queue_bound, qcount <= tbpe_pkg::QCNT_W'(tbpe_pkg::QUEUE_DEPTH), "queue overfilled")
  `TBPE_ASSERT(a_dot_bound, dot_q < 9'(tbpe_pkg::LINE_DOTS), "dot count past line end")
  `TBPE_ASSERT(a_xfer_visible, (mode_q != tbpe_pkg::MODE_XFER) || (line_q <= 8'(tbpe_pkg::LAST_VISIBLE)), "pixel transfer in blanking")
  `TBPE_ASSERT_NEXT(a_pixel_column, acc && pvalid, m_axis_tdata[10:3] < 8'(tbpe_pkg::SCREEN_WIDTH), "pixel column off screen")

endmodule
